/* hdl/nsp_pkg.sv */
// nsp_pkg: shared types, character codes, parser modes and event codes
package nsp_pkg;

    localparam int TCNT_W = 6;
    localparam int CNT_W  = 32;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_DATA  = 3'd2;
    localparam logic [2:0] MODE_CKSUM = 3'd3;
    localparam logic [2:0] MODE_DONE  = 3'd4;

    localparam logic [3:0] EV_IGNORED     = 4'd0;
    localparam logic [3:0] EV_START       = 4'd1;
    localparam logic [3:0] EV_STORED      = 4'd2;
    localparam logic [3:0] EV_DROPPED     = 4'd3;
    localparam logic [3:0] EV_IDENT_END   = 4'd4;
    localparam logic [3:0] EV_TERM_END    = 4'd5;
    localparam logic [3:0] EV_CK_CAPTURED = 4'd6;
    localparam logic [3:0] EV_FRAMING     = 4'd7;
    localparam logic [3:0] EV_OK          = 4'd8;
    localparam logic [3:0] EV_CK_FAIL     = 4'd9;
    localparam logic [3:0] EV_TOO_MANY    = 4'd10;

    typedef struct packed {
        logic [3:0]        event_res;
        logic [7:0]        term_char;
        logic [TCNT_W-1:0] term_index;
        logic [3:0]        char_pos;
        logic [3:0]        term_length;
        logic [7:0]        running_parity;
        logic [7:0]        received_checksum;
        logic [CNT_W-1:0]  byte_count;
        logic [CNT_W-1:0]  fail_count;
        logic [CNT_W-1:0]  checksum_fail_count;
        logic [CNT_W-1:0]  checksum_pass_count;
    } result_t;

    function automatic logic [3:0] hex_val(input logic [7:0] ch);
        logic [3:0] v;
        v = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            v = 4'(ch - 8'h37);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            v = 4'(ch - 8'h57);
        end
        return v;
    endfunction

endpackage

/* hdl/nsp_engine.sv */
// nsp_engine: parser state, per-character update logic and result register
module nsp_engine #(
    parameter int TERM_SIZE = 16,
    parameter int MAX_TERMS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_i,
    input  logic [7:0]       byte_i,
    output nsp_pkg::result_t result_o
);
    import nsp_pkg::*;

    localparam int TPOS_W = $clog2(TERM_SIZE);

    logic [2:0]        mode_reg, mode_next;
    logic [7:0]        parity_reg, parity_next;
    logic [TPOS_W-1:0] tpos_reg, tpos_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic [7:0]        dig0_reg, dig0_next;
    logic [7:0]        dig1_reg, dig1_next;
    logic [CNT_W-1:0]  bytes_reg, bytes_next;
    logic [CNT_W-1:0]  fails_reg, fails_next;
    logic [CNT_W-1:0]  cfails_reg, cfails_next;
    logic [CNT_W-1:0]  passes_reg, passes_next;
    result_t           res_reg, res_next;

    logic [3:0]        ev;
    logic [7:0]        tchar;
    logic [TCNT_W-1:0] tidx;
    logic [TPOS_W-1:0] cpos;
    logic [TPOS_W-1:0] tlen;
    logic              fail_inc;
    logic              cfail_inc;
    logic              pass_inc;
    logic [7:0]        ck_cur;
    logic [7:0]        ck_next;
    logic [6:0]        cpos_wide;
    logic [6:0]        tlen_wide;

    always_comb begin
        mode_next   = mode_reg;
        parity_next = parity_reg;
        tpos_next   = tpos_reg;
        tcnt_next   = tcnt_reg;
        dig0_next   = dig0_reg;
        dig1_next   = dig1_reg;
        ev          = EV_IGNORED;
        tchar       = 8'd0;
        tidx        = tcnt_reg;
        cpos        = '0;
        tlen        = '0;
        fail_inc    = 1'b0;
        cfail_inc   = 1'b0;
        pass_inc    = 1'b0;
        ck_cur      = {hex_val(dig0_reg), hex_val(dig1_reg)};

        if (byte_i == CH_DOLLAR) begin
            mode_next   = MODE_IDENT;
            parity_next = 8'd0;
            tpos_next   = '0;
            tcnt_next   = '0;
            dig0_next   = 8'd0;
            dig1_next   = 8'd0;
            tidx        = '0;
            ev          = EV_START;
        end else if (mode_reg == MODE_IDENT || mode_reg == MODE_DATA) begin
            if (byte_i == CH_COMMA || byte_i == CH_STAR) begin
                tlen      = tpos_reg;
                tpos_next = '0;
                if (byte_i == CH_COMMA && mode_reg == MODE_IDENT) begin
                    parity_next = parity_reg ^ byte_i;
                    mode_next   = MODE_DATA;
                    ev          = EV_IDENT_END;
                end else if (tcnt_reg >= TCNT_W'(MAX_TERMS)) begin
                    fail_inc  = 1'b1;
                    mode_next = MODE_IDLE;
                    ev        = EV_TOO_MANY;
                end else begin
                    tcnt_next = tcnt_reg + TCNT_W'(1);
                    ev        = EV_TERM_END;
                    if (byte_i == CH_COMMA) begin
                        parity_next = parity_reg ^ byte_i;
                        mode_next   = MODE_DATA;
                    end else begin
                        mode_next = MODE_CKSUM;
                        dig0_next = 8'd0;
                        dig1_next = 8'd0;
                    end
                end
            end else if (byte_i == CH_CR || byte_i == CH_LF) begin
                fail_inc  = 1'b1;
                mode_next = MODE_IDLE;
                ev        = EV_FRAMING;
            end else begin
                parity_next = parity_reg ^ byte_i;
                if (tpos_reg < TPOS_W'(TERM_SIZE - 1)) begin
                    cpos      = tpos_reg;
                    tchar     = byte_i;
                    tpos_next = tpos_reg + TPOS_W'(1);
                    ev        = EV_STORED;
                end else begin
                    fail_inc = 1'b1;
                    ev       = EV_DROPPED;
                end
            end
        end else if (mode_reg == MODE_CKSUM) begin
            if (byte_i == CH_CR) begin
                if (tpos_reg >= TPOS_W'(2)) begin
                    tpos_next = '0;
                    mode_next = MODE_DONE;
                    ev        = EV_CK_CAPTURED;
                end else begin
                    fail_inc  = 1'b1;
                    mode_next = MODE_IDLE;
                    ev        = EV_FRAMING;
                end
            end else if (byte_i == CH_LF || byte_i == CH_COMMA || byte_i == CH_STAR) begin
                fail_inc  = 1'b1;
                mode_next = MODE_IDLE;
                ev        = EV_FRAMING;
            end else if (tpos_reg < TPOS_W'(2)) begin
                if (tpos_reg[0]) begin
                    dig1_next = byte_i;
                end else begin
                    dig0_next = byte_i;
                end
                cpos      = tpos_reg;
                tchar     = byte_i;
                tpos_next = tpos_reg + TPOS_W'(1);
                ev        = EV_STORED;
            end else begin
                fail_inc = 1'b1;
                ev       = EV_DROPPED;
            end
        end else if (mode_reg == MODE_DONE) begin
            if (byte_i == CH_LF) begin
                if (parity_reg == ck_cur) begin
                    pass_inc = 1'b1;
                    ev       = EV_OK;
                end else begin
                    cfail_inc = 1'b1;
                    fail_inc  = 1'b1;
                    ev        = EV_CK_FAIL;
                end
                mode_next = MODE_IDLE;
            end else begin
                fail_inc  = 1'b1;
                mode_next = MODE_IDLE;
                ev        = EV_FRAMING;
            end
        end

        bytes_next  = bytes_reg + CNT_W'(1);
        fails_next  = fails_reg + CNT_W'(fail_inc);
        cfails_next = cfails_reg + CNT_W'(cfail_inc);
        passes_next = passes_reg + CNT_W'(pass_inc);
        ck_next     = {hex_val(dig0_next), hex_val(dig1_next)};
        cpos_wide   = 7'(cpos);
        tlen_wide   = 7'(tlen);

        res_next.event_res           = ev;
        res_next.term_char           = tchar;
        res_next.term_index          = tidx;
        res_next.char_pos            = cpos_wide[3:0];
        res_next.term_length         = tlen_wide[3:0];
        res_next.running_parity      = parity_next;
        res_next.received_checksum   = ck_next;
        res_next.byte_count          = bytes_next;
        res_next.fail_count          = fails_next;
        res_next.checksum_fail_count = cfails_next;
        res_next.checksum_pass_count = passes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            parity_reg <= 8'd0;
            tpos_reg   <= '0;
            tcnt_reg   <= '0;
            dig0_reg   <= 8'd0;
            dig1_reg   <= 8'd0;
            bytes_reg  <= '0;
            fails_reg  <= '0;
            cfails_reg <= '0;
            passes_reg <= '0;
        end else if (step_i) begin
            mode_reg   <= mode_next;
            parity_reg <= parity_next;
            tpos_reg   <= tpos_next;
            tcnt_reg   <= tcnt_next;
            dig0_reg   <= dig0_next;
            dig1_reg   <= dig1_next;
            bytes_reg  <= bytes_next;
            fails_reg  <= fails_next;
            cfails_reg <= cfails_next;
            passes_reg <= passes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_i) begin
            res_reg <= res_next;
        end
    end

    assign result_o = res_reg;

    // byte and fail counters in the result match the live state
    a_bytes_track: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i |=> res_reg.byte_count == bytes_reg && res_reg.fail_count == fails_reg)
        else $error("byte or fail count in result does not match state");

    // dollar restarts the sentence
    a_dollar_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && byte_i == CH_DOLLAR |=> mode_reg == MODE_IDENT && parity_reg == 8'd0
            && tcnt_reg == '0 && res_reg.event_res == EV_START)
        else $error("dollar did not restart the sentence");

    // checksum fail count moves only on a checksum fail event
    a_cfail_event: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i |=> (res_reg.event_res == EV_CK_FAIL) == (cfails_reg != $past(cfails_reg)))
        else $error("checksum fail count out of step with events");

    // term position never passes the term size
    a_tpos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tpos_reg <= TPOS_W'(TERM_SIZE - 1))
        else $error("term position beyond term size");

endmodule

/* hdl/nmea_sentence_parser.sv */
// nmea_sentence_parser: top level with input beat register and result handshake
// an accepted beat is held in the input beat register, then its result in the engine result register
// throughput: one character per cycle while the result side is not stalled, set by the single-pass update in nsp_engine
// a stalled result holds its register while the input register takes one more beat
// reset (aresetn low, synchronous) empties both registers, sets parse mode idle
// and clears parity, term position, term count, checksum digits and all counters
module nmea_sentence_parser #(
    parameter int TERM_SIZE = 16,
    parameter int MAX_TERMS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_in_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_event_res,
    output logic [7:0]                   m_term_char,
    output logic [nsp_pkg::TCNT_W-1:0]   m_term_index,
    output logic [3:0]                   m_char_pos,
    output logic [3:0]                   m_term_length,
    output logic [7:0]                   m_running_parity,
    output logic [7:0]                   m_received_checksum,
    output logic [nsp_pkg::CNT_W-1:0]    m_byte_count,
    output logic [nsp_pkg::CNT_W-1:0]    m_fail_count,
    output logic [nsp_pkg::CNT_W-1:0]    m_checksum_fail_count,
    output logic [nsp_pkg::CNT_W-1:0]    m_checksum_pass_count
);
    import nsp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg, m_valid_next;
    logic       step;
    result_t    result;

    assign step    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    nsp_engine #(
        .TERM_SIZE (TERM_SIZE),
        .MAX_TERMS (MAX_TERMS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_i   (step),
        .byte_i   (in_byte_reg),
        .result_o (result)
    );

    assign m_valid               = m_valid_reg;
    assign m_event_res           = result.event_res;
    assign m_term_char           = result.term_char;
    assign m_term_index          = result.term_index;
    assign m_char_pos            = result.char_pos;
    assign m_term_length         = result.term_length;
    assign m_running_parity      = result.running_parity;
    assign m_received_checksum   = result.received_checksum;
    assign m_byte_count          = result.byte_count;
    assign m_fail_count          = result.fail_count;
    assign m_checksum_fail_count = result.checksum_fail_count;
    assign m_checksum_pass_count = result.checksum_pass_count;

    // a held beat is not lost while the result side stalls
    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg))
        else $error("buffered beat lost during stall");

    // an engine step always leaves a result to deliver
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("engine step produced no result beat");

    // ready is low only with a buffered beat that cannot move
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without cause");

endmodule
